// ===== hw/rtl/triv_pkg.sv =====
`default_nettype none

package triv_pkg;

  // Register lengths of the three feedback shift registers.
  localparam int unsigned LEN_A = 93;
  localparam int unsigned LEN_B = 84;
  localparam int unsigned LEN_C = 111;

  // Key and IV length, and rounds per byte.
  localparam int unsigned KEY_W       = 80;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WARM_ROUNDS = 1152;
  localparam int unsigned WARM_STEPS  = WARM_ROUNDS / BYTE_W;
  localparam int unsigned WARM_CNT_W  = $clog2(WARM_STEPS);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned UPPER_W    = KEY_W - CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_UPPER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOWER  = 3'd3;

  // One queued input word.
  typedef struct packed {
    logic              restart;
    logic [BYTE_W-1:0] data;
  } triv_item_t;

  // Key and IV as loaded on a restart.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] iv;
  } triv_seed_t;

  // Complete cipher state.
  typedef struct packed {
    logic [LEN_A-1:0] a;
    logic [LEN_B-1:0] b;
    logic [LEN_C-1:0] c;
  } triv_state_t;

  // Core sequencer states.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_WARM,
    ST_LAST
  } triv_fsm_t;

  // Keystream bit of the current state.
  function automatic logic triv_zbit(triv_state_t s);
    triv_zbit = s.a[65] ^ s.a[92] ^ s.b[68] ^ s.b[83] ^ s.c[65] ^ s.c[110];
  endfunction

  // One round: every register shifts up by one cell and takes its feedback in cell 0.
  function automatic triv_state_t triv_round(triv_state_t s);
    logic        t1;
    logic        t2;
    logic        t3;
    triv_state_t n;
    t1  = s.a[65] ^ s.a[92] ^ (s.a[90] & s.a[91]) ^ s.b[77];
    t2  = s.b[68] ^ s.b[83] ^ (s.b[81] & s.b[82]) ^ s.c[86];
    t3  = s.c[65] ^ s.c[110] ^ (s.c[108] & s.c[109]) ^ s.a[68];
    n.a = {s.a[LEN_A-2:0], t3};
    n.b = {s.b[LEN_B-2:0], t1};
    n.c = {s.c[LEN_C-2:0], t2};
    triv_round = n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/triv_if.sv =====
`default_nettype none

// Input channel: one byte plus the restart flag per word.
interface triv_in_if;
  logic                          valid;
  logic                          ready;
  logic [triv_pkg::BYTE_W-1:0]   in_byte;
  logic                          restart;
  modport source (output valid, output in_byte, output restart, input ready);
  modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

// Result channel: one byte per word.
interface triv_out_if;
  logic                          valid;
  logic                          ready;
  logic [triv_pkg::BYTE_W-1:0]   out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

// Configuration write channel.
interface triv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [triv_pkg::CFG_IDX_W-1:0]    index;
  logic [triv_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trivium_stream_cipher_top.sv =====
// Trivium stream cipher, 80-bit key and IV, one byte per word.
// Channels: in_ch carries in_byte and restart, out_ch returns out_byte,
// cfg_ch writes key_upper, key_lower, iv_upper and iv_lower at indexes 0 to 3;
// other indexes are ignored. The configuration port is always ready.
// Each word is XORed with eight keystream bits, the first bit at the MSB, so
// the same operation encrypts and decrypts.
// Throughput: one byte per cycle while out_ch is ready and no restart runs;
// eight rounds are unrolled in the core. A plain byte goes from the head
// of the two-entry input queue through the result register to out_ch.
// A word with restart set first reloads the state from key and IV, then
// runs 1152 warm-up rounds eight at a time before its own byte is ciphered.
// New key or IV values take effect at the next restart.
// Reset (rst_n low, synchronous) clears the cipher state and the key and IV
// registers; until the first restart the keystream is all zeros.
// On a receiver stall the result register holds its byte, the core pops no
// words (warm-up goes on) and the queue fills; in_ch.ready drops at two words.
`default_nettype none

module trivium_stream_cipher_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  triv_in_if.sink    in_ch,
  triv_out_if.source out_ch,
  triv_cfg_if.sink   cfg_ch
);

  logic [triv_pkg::UPPER_W-1:0]     key_upper_r;
  logic [triv_pkg::CFG_DATA_W-1:0]  key_lower_r;
  logic [triv_pkg::UPPER_W-1:0]     iv_upper_r;
  logic [triv_pkg::CFG_DATA_W-1:0]  iv_lower_r;
  triv_pkg::triv_seed_t             seed;
  triv_pkg::triv_item_t             in_item;
  triv_pkg::triv_item_t             head_item;
  logic                             head_valid;
  logic                             head_pop;
  logic                             cfg_we;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      iv_upper_r  <= '0;
      iv_lower_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_ch.index)
        triv_pkg::CFG_KEY_UPPER: key_upper_r <= cfg_ch.data[triv_pkg::UPPER_W-1:0];
        triv_pkg::CFG_KEY_LOWER: key_lower_r <= cfg_ch.data;
        triv_pkg::CFG_IV_UPPER:  iv_upper_r  <= cfg_ch.data[triv_pkg::UPPER_W-1:0];
        triv_pkg::CFG_IV_LOWER:  iv_lower_r  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  assign seed.key = {key_upper_r, key_lower_r};
  assign seed.iv  = {iv_upper_r, iv_lower_r};

  assign in_item.restart = in_ch.restart;
  assign in_item.data    = in_ch.in_byte;

  // Front: input queue.
  triv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  // Back: cipher core with result register.
  triv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .out_ready  (out_ch.ready)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/triv_front.sv =====
`default_nettype none

// Accepts input words into a two-entry queue and presents the oldest one to the core.
module triv_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire triv_pkg::triv_item_t in_item,
  output logic                      head_valid,
  output triv_pkg::triv_item_t      head_item,
  input  wire logic                 head_pop
);

  triv_pkg::triv_item_t q_r [2];
  logic                 wr_ptr_r;
  logic                 wr_ptr_nxt;
  logic                 rd_ptr_r;
  logic                 rd_ptr_nxt;
  logic [1:0]           cnt_r;
  logic [1:0]           cnt_nxt;
  logic                 push;
  logic                 pop;

  assign in_ready   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triv_core.sv =====
`default_nettype none

// Cipher core: loads and warms up the state on a restart, then runs eight rounds per byte.
module triv_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire triv_pkg::triv_seed_t        seed,
  input  wire logic                        head_valid,
  input  wire triv_pkg::triv_item_t        head_item,
  output logic                             head_pop,
  output logic                             out_valid,
  output logic [triv_pkg::BYTE_W-1:0]      out_byte,
  input  wire logic                        out_ready
);

  triv_pkg::triv_fsm_t                  fsm_r;
  triv_pkg::triv_fsm_t                  fsm_nxt;
  triv_pkg::triv_state_t                st_r;
  triv_pkg::triv_state_t                st_nxt;
  triv_pkg::triv_state_t                st_load;
  triv_pkg::triv_state_t                st_step;
  logic [triv_pkg::WARM_CNT_W-1:0]      cnt_r;
  logic [triv_pkg::WARM_CNT_W-1:0]      cnt_nxt;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic [triv_pkg::BYTE_W-1:0]          out_byte_r;
  logic [triv_pkg::BYTE_W-1:0]          out_byte_nxt;
  logic [triv_pkg::BYTE_W-1:0]          ks;
  logic                                 out_free;
  logic                                 emit;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_free  = !out_valid_r || out_ready;

  // Fresh state from key and IV; the first key or IV bit goes to cell 0.
  always_comb begin
    st_load = '0;
    for (int i = 0; i < triv_pkg::KEY_W; i++) begin
      st_load.a[i] = seed.key[triv_pkg::KEY_W-1-i];
      st_load.b[i] = seed.iv[triv_pkg::KEY_W-1-i];
    end
    st_load.c[triv_pkg::LEN_C-1] = 1'b1;
    st_load.c[triv_pkg::LEN_C-2] = 1'b1;
    st_load.c[triv_pkg::LEN_C-3] = 1'b1;
  end

  // Eight rounds; the first keystream bit lands in the byte's top bit.
  always_comb begin
    st_step = st_r;
    ks      = '0;
    for (int i = 0; i < triv_pkg::BYTE_W; i++) begin
      ks[triv_pkg::BYTE_W-1-i] = triv_pkg::triv_zbit(st_step);
      st_step                  = triv_pkg::triv_round(st_step);
    end
  end

  // Sequencer: next state and outputs.
  always_comb begin
    fsm_nxt       = fsm_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    head_pop      = 1'b0;
    case (fsm_r)
      triv_pkg::ST_RUN: begin
        if (head_valid && head_item.restart) begin
          st_nxt  = st_load;
          cnt_nxt = '0;
          fsm_nxt = triv_pkg::ST_WARM;
        end else if (head_valid && out_free) begin
          st_nxt   = st_step;
          emit     = 1'b1;
          head_pop = 1'b1;
        end
      end
      triv_pkg::ST_WARM: begin
        st_nxt  = st_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == triv_pkg::WARM_CNT_W'(triv_pkg::WARM_STEPS - 1)) begin
          fsm_nxt = triv_pkg::ST_LAST;
        end
      end
      triv_pkg::ST_LAST: begin
        if (out_free) begin
          st_nxt   = st_step;
          emit     = 1'b1;
          head_pop = 1'b1;
          fsm_nxt  = triv_pkg::ST_RUN;
        end
      end
      default: begin
        fsm_nxt = triv_pkg::ST_RUN;
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && !out_ready);
    out_byte_nxt  = emit ? (head_item.data ^ ks) : out_byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= triv_pkg::ST_RUN;
      st_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result byte needs no reset; its valid flag qualifies it.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triv_checker.sv =====
`default_nettype none

// Port-level checks on the cipher block.
module triv_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [triv_pkg::BYTE_W-1:0]     out_byte,
  input wire logic                            cfg_ready
);

  // A stalled result byte keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result word changed while stalled");

  // Right after reset no result is shown and the queue is open.
  a_reset_out: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) $past(!rst_n) |-> in_ready)
    else $error("input not ready right after reset");

  // Configuration writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind trivium_stream_cipher_top triv_checker u_triv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .cfg_ready (cfg_ch.ready)
);

`default_nettype wire
